/* src/poc_pkg.sv */
// Shared types and constants for the pulse output controller.
// No dependencies; every other file of the block imports this package.
package poc_pkg;

   // Number of outputs handled and the widths that follow from it
   localparam int OUTPUT_COUNT = 16;
   localparam int IDX_W        = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
   localparam int CNT_W        = $clog2(OUTPUT_COUNT + 1);

   // Fixed field widths
   localparam int PIN_W      = 16;
   localparam int TIME_W     = 32;
   localparam int WIDTH_W    = 16;
   localparam int NUM_W      = 5;
   localparam int LVL_W      = 2;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Outputs that exist; bits above the count are ignored in the mask
   localparam logic [PIN_W-1:0] OUT_MASK = PIN_W'((32'd1 << OUTPUT_COUNT) - 32'd1);

   // Register reset values
   localparam logic [PIN_W-1:0]   MASK_RESET  = '0;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(100);

   // Transaction opcodes
   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE   = 2'd0,
      MODE_TICK    = 2'd1,
      MODE_FORWARD = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_MASK  = 1'b0,
      CSR_PULSE_WIDTH = 1'b1
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_TICK_INC,
      ST_TICK_SCAN,
      ST_FORWARD,
      ST_CLEAR
   } state_type;

   // Operations of the shared time adder
   typedef enum logic [1:0] {
      ALU_INC,
      ALU_ARM,
      ALU_CMP
   } alu_op_type;

   // Sequencer to datapath control
   typedef struct packed {
      logic             do_write;
      logic             do_inc;
      logic             scan_eval;
      logic [IDX_W-1:0] scan_idx;
      logic [IDX_W-1:0] rd_idx;
      logic             do_forward;
      logic             do_clear;
      logic             finish;
   } ctrl_type;

endpackage

/* src/poc_if.sv */
// Request and response channel interfaces of the pulse output controller.
// Depends on poc_pkg for the field widths.
interface poc_req_if;
   import poc_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [NUM_W-1:0]    pin_number;
   logic [LVL_W-1:0]    level;
   logic [PIN_W-1:0]    physical_inputs;

   modport source (output valid, mode, pin_number, level, physical_inputs, input ready);
   modport sink (input valid, mode, pin_number, level, physical_inputs, output ready);
endinterface

interface poc_rsp_if;
   import poc_pkg::*;

   logic             valid;
   logic             ready;
   logic             accepted;
   logic [PIN_W-1:0] pin_levels;
   logic [PIN_W-1:0] merged_outputs;
   logic [PIN_W-1:0] pulses_running;

   modport source (output valid, accepted, pin_levels, merged_outputs, pulses_running,
                   input ready);
   modport sink (input valid, accepted, pin_levels, merged_outputs, pulses_running,
                 output ready);
endinterface

/* src/poc_time_alu.sv */
// Shared 32-bit time adder: increment, deadline arming and wrap-safe compare.
// Depends on poc_pkg.
module poc_time_alu (
   input  poc_pkg::alu_op_type              op,
   input  logic [poc_pkg::TIME_W-1:0]       time_ms,
   input  logic [poc_pkg::WIDTH_W-1:0]      width_ms,
   input  logic [poc_pkg::TIME_W-1:0]       deadline,
   output logic [poc_pkg::TIME_W-1:0]       sum
);
   import poc_pkg::*;

   logic [TIME_W-1:0] operand;
   logic              carry_in;

   // Pick the second operand; subtract is add of the inverse plus one
   always_comb begin
      case (op)
         ALU_INC: begin
            operand  = TIME_W'(1);
            carry_in = 1'b0;
         end
         ALU_ARM: begin
            operand  = TIME_W'(width_ms);
            carry_in = 1'b0;
         end
         default: begin
            operand  = ~deadline;
            carry_in = 1'b1;
         end
      endcase
   end

   assign sum = time_ms + operand + TIME_W'(carry_in);

endmodule

/* src/poc_deadline_mem.sv */
// Deadline store: one 32-bit entry per output, one write and one read port.
// Depends on poc_pkg; read data is registered.
module poc_deadline_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [poc_pkg::IDX_W-1:0]    wr_addr,
   input  logic [poc_pkg::TIME_W-1:0]   wr_data,
   input  logic [poc_pkg::IDX_W-1:0]    rd_addr,
   output logic [poc_pkg::TIME_W-1:0]   rd_data
);
   import poc_pkg::*;

   logic [TIME_W-1:0] mem_ff [OUTPUT_COUNT];
   logic [TIME_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/poc_sequencer.sv */
// Sequencer: decodes each transaction and steps the deadline scan of a tick.
// Depends on poc_pkg for the state, opcode and control types.
module poc_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  poc_pkg::mode_type req_mode,
   output poc_pkg::ctrl_type ctrl,
   output logic              idle
);
   import poc_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             scan_last;

   assign scan_last = (cnt_ff == CNT_W'(OUTPUT_COUNT));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_mode)
                  MODE_WRITE:   state_in = ST_WRITE;
                  MODE_TICK:    state_in = ST_TICK_INC;
                  MODE_FORWARD: state_in = ST_FORWARD;
                  MODE_CLEAR:   state_in = ST_CLEAR;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE, ST_FORWARD, ST_CLEAR: state_in = ST_IDLE;
         ST_TICK_INC:                    state_in = ST_TICK_SCAN;
         ST_TICK_SCAN: begin
            if (scan_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Scan counter: reads entry cnt while evaluating entry cnt-1
   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_TICK_INC) begin
         cnt_in = '0;
      end else if (state_ff == ST_TICK_SCAN) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // Outputs
   always_comb begin
      ctrl          = '0;
      ctrl.rd_idx   = cnt_ff[IDX_W-1:0];
      ctrl.scan_idx = IDX_W'(cnt_ff - CNT_W'(1));
      idle          = 1'b0;
      unique case (state_ff)
         ST_IDLE:     idle = 1'b1;
         ST_WRITE: begin
            ctrl.do_write = 1'b1;
            ctrl.finish   = 1'b1;
         end
         ST_TICK_INC: ctrl.do_inc = 1'b1;
         ST_TICK_SCAN: begin
            ctrl.scan_eval = (cnt_ff != '0);
            ctrl.finish    = scan_last;
         end
         ST_FORWARD: begin
            ctrl.do_forward = 1'b1;
            ctrl.finish     = 1'b1;
         end
         ST_CLEAR: begin
            ctrl.do_clear = 1'b1;
            ctrl.finish   = 1'b1;
         end
         default: idle = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* src/pulse_output_controller_top.sv */
// Top level of the pulse output controller: registers, output state and datapath.
// Depends on poc_pkg, poc_if, poc_time_alu, poc_deadline_mem and poc_sequencer.
//
// Usage: each transaction on req_chan carries a mode. A write sets the level of one
// output (numbered from one); pulse-mode outputs fire a one-shot on a rising request.
// A tick advances the millisecond count and walks all deadline entries through one
// shared 32-bit adder, one entry a cycle. A forward merges physical_inputs with the
// logical levels of pulse outputs. A soft clear drops all logical levels and pulses;
// pin levels are kept. Exactly one response per request appears on rsp_chan.
// A write, forward or clear passes through one sequencer state before its response
// is registered; a tick passes through an increment state and then a scan that
// reads each deadline entry from the store and evaluates it in the next cycle.
// One request is worked on at a time; a new one is taken when the sequencer is idle
// and the response register is empty or is being drained in the same cycle.
// If the receiver stalls, the response stays in its register and no further
// request is taken. Configuration writes on csr_ apply from the next cycle.
// Reset clears all levels, pulses, time and configuration registers to their reset
// values; the deadline store is not cleared, as entries are used only while armed.
module pulse_output_controller_top (
   input  logic                             clock,
   input  logic                             reset,
   poc_req_if.sink                          req_chan,
   poc_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_en,
   input  logic [poc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [poc_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import poc_pkg::*;

   // Configuration registers
   logic [PIN_W-1:0]   mask_ff;
   logic [WIDTH_W-1:0] width_ff;

   // Controller state
   logic [PIN_W-1:0]  logical_ff, logical_in;
   logic [PIN_W-1:0]  running_ff, running_in;
   logic [PIN_W-1:0]  applied_ff, applied_in;
   logic [PIN_W-1:0]  pins_ff, pins_in;
   logic [TIME_W-1:0] time_ff, time_in;

   // Captured request payload
   logic [NUM_W-1:0] num_ff;
   logic [LVL_W-1:0] level_ff;
   logic [PIN_W-1:0] phys_ff;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_acc_ff;
   logic [PIN_W-1:0] rsp_pins_ff;
   logic [PIN_W-1:0] rsp_merged_ff;
   logic [PIN_W-1:0] rsp_running_ff;

   ctrl_type          ctrl;
   logic              seq_idle;
   logic              req_fire;
   alu_op_type        alu_op;
   logic [TIME_W-1:0] alu_sum;
   logic [TIME_W-1:0] rd_deadline;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [PIN_W-1:0]  pm;
   logic              accepted_v;
   logic [PIN_W-1:0]  merged_v;
   logic              wr_ok;
   logic [IDX_W-1:0]  wr_idx;
   logic [PIN_W-1:0]  wr_bit;
   logic [PIN_W-1:0]  scan_bit;
   logic              scan_changed;
   logic              scan_pm;
   logic              scan_logical;
   logic              scan_arm;

   // Handshake: take a request when idle and the response slot frees up
   assign req_chan.ready = seq_idle && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   poc_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_mode (mode_type'(req_chan.mode)),
      .ctrl     (ctrl),
      .idle     (seq_idle)
   );

   poc_time_alu u_alu (
      .op       (alu_op),
      .time_ms  (time_ff),
      .width_ms (width_ff),
      .deadline (rd_deadline),
      .sum      (alu_sum)
   );

   poc_deadline_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (alu_sum),
      .rd_addr (ctrl.rd_idx),
      .rd_data (rd_deadline)
   );

   assign pm = mask_ff & OUT_MASK;

   // Write decode
   assign wr_ok  = (num_ff != '0) && (num_ff <= NUM_W'(OUTPUT_COUNT)) && (level_ff <= LVL_W'(1));
   assign wr_idx = IDX_W'(num_ff - NUM_W'(1));
   assign wr_bit = PIN_W'(1) << wr_idx;

   // Scan entry decode
   assign scan_bit     = PIN_W'(1) << ctrl.scan_idx;
   assign scan_changed = |((pm ^ applied_ff) & scan_bit);
   assign scan_pm      = |(pm & scan_bit);
   assign scan_logical = |(logical_ff & scan_bit);
   assign scan_arm     = scan_changed && scan_pm && scan_logical;

   // Adder operation select
   always_comb begin
      alu_op = ALU_CMP;
      if (ctrl.do_inc) begin
         alu_op = ALU_INC;
      end else if (ctrl.do_write || (ctrl.scan_eval && scan_arm)) begin
         alu_op = ALU_ARM;
      end
   end

   // Next state of outputs, pulses and time
   always_comb begin
      logical_in = logical_ff;
      running_in = running_ff;
      applied_in = applied_ff;
      pins_in    = pins_ff;
      time_in    = time_ff;
      accepted_v = 1'b1;
      merged_v   = '0;
      mem_we     = 1'b0;
      mem_waddr  = wr_idx;

      if (ctrl.do_inc) begin
         time_in = alu_sum;
      end

      if (ctrl.do_write) begin
         if (!wr_ok) begin
            accepted_v = 1'b0;
         end else if (level_ff == '0) begin
            logical_in = logical_ff & ~wr_bit;
            running_in = running_ff & ~wr_bit;
            pins_in    = pins_ff & ~wr_bit;
         end else if ((pm & wr_bit) == '0) begin
            logical_in = logical_ff | wr_bit;
            running_in = running_ff & ~wr_bit;
            pins_in    = pins_ff | wr_bit;
         end else if ((logical_ff & wr_bit) == '0) begin
            // rising request on a pulse output: fire and arm
            logical_in = logical_ff | wr_bit;
            running_in = running_ff | wr_bit;
            pins_in    = pins_ff | wr_bit;
            mem_we     = 1'b1;
         end
      end

      if (ctrl.scan_eval) begin
         mem_waddr = ctrl.scan_idx;
         if (scan_changed && !scan_pm) begin
            // left pulse mode: follow the logical level
            running_in = running_ff & ~scan_bit;
            pins_in    = scan_logical ? (pins_ff | scan_bit) : (pins_ff & ~scan_bit);
         end else if (scan_arm) begin
            // entered pulse mode while high; a zero width expires at once
            if (width_ff == '0) begin
               running_in = running_ff & ~scan_bit;
               pins_in    = pins_ff & ~scan_bit;
            end else begin
               running_in = running_ff | scan_bit;
               pins_in    = pins_ff | scan_bit;
               mem_we     = 1'b1;
            end
         end else if (((running_ff & scan_bit) != '0) && !alu_sum[TIME_W-1]) begin
            // deadline reached
            running_in = running_ff & ~scan_bit;
            pins_in    = pins_ff & ~scan_bit;
         end
         if (ctrl.finish) begin
            applied_in = pm;
         end
      end

      if (ctrl.do_forward) begin
         merged_v = (phys_ff & ~pm) | (logical_ff & pm);
      end

      if (ctrl.do_clear) begin
         logical_in = '0;
         running_in = '0;
         applied_in = pm;
      end
   end

   // Response slot: load at the end of a transaction, free on handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= MASK_RESET;
         width_ff     <= WIDTH_RESET;
         logical_ff   <= '0;
         running_ff   <= '0;
         applied_ff   <= MASK_RESET & OUT_MASK;
         pins_ff      <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_PULSE_MASK:  mask_ff  <= PIN_W'(csr_write_data);
               CSR_PULSE_WIDTH: width_ff <= WIDTH_W'(csr_write_data);
               default:         mask_ff  <= mask_ff;
            endcase
         end
         logical_ff   <= logical_in;
         running_ff   <= running_in;
         applied_ff   <= applied_in;
         pins_ff      <= pins_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         num_ff   <= req_chan.pin_number;
         level_ff <= req_chan.level;
         phys_ff  <= req_chan.physical_inputs;
      end
      if (ctrl.finish) begin
         rsp_acc_ff     <= accepted_v;
         rsp_pins_ff    <= pins_in;
         rsp_merged_ff  <= merged_v;
         rsp_running_ff <= running_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.accepted       = rsp_acc_ff;
   assign rsp_chan.pin_levels     = rsp_pins_ff;
   assign rsp_chan.merged_outputs = rsp_merged_ff;
   assign rsp_chan.pulses_running = rsp_running_ff;

`ifndef SYNTHESIS
   a_running_drives_pin: assert property (@(posedge clock) disable iff (reset)
      (running_ff & ~pins_ff) == '0)
      else $error("pulse timing on an output whose pin is low");

   a_running_in_range: assert property (@(posedge clock) disable iff (reset)
      (running_ff & ~OUT_MASK) == '0)
      else $error("pulse timing on a nonexistent output");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !rsp_valid_ff)
      else $error("response slot busy right after a request was taken");

   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      !ctrl.do_inc |=> $stable(time_ff))
      else $error("millisecond count moved outside a tick increment");
`endif

endmodule
